// ----- src/fpcmc_pkg.sv -----
// Package with the command codes and shared types of the compare, min/max and classify block.
`default_nettype none
package fpcmc_pkg;
    typedef enum logic [2:0] {
        CMD_EQ    = 3'd0,
        CMD_LE    = 3'd1,
        CMD_LT    = 3'd2,
        CMD_MIN   = 3'd3,
        CMD_MAX   = 3'd4,
        CMD_CLASS = 3'd5
    } t_cmd;

    localparam logic [63:0] SP_CANON_NAN = 64'h0000_0000_7FC0_0000;
    localparam logic [63:0] DP_CANON_NAN = 64'h7FF8_0000_0000_0000;

    typedef struct packed {
        logic sign;
        logic exp_max;
        logic exp_zero;
        logic frac_zero;
        logic quiet;
    } t_opinfo;
endpackage
`default_nettype wire

// ----- src/fp_compare_minmax_classify.sv -----
// Top level of the floating-point compare, min/max and classify pipeline.
// Usage: one beat on the slave side carries a command, a precision bit and two raw
// operands; one beat on the master side returns the 64-bit result and the invalid flag.
// s_axis_tdata packs command[2:0], is_double[3], operand_a[67:4], operand_b[131:68].
// m_axis_tdata packs result[63:0], invalid[64], zero padded to 72 bits.
// The pipe has three register stages: operand decode, magnitude compare, and
// result selection with an output register. An accepted beat passes through the
// decode, compare and output registers before it is valid on the master side.
// Throughput is one beat per cycle; a new beat is taken every cycle while the
// output side accepts.
// When the receiver stalls, each full stage holds while empty stages still fill,
// and s_axis_tready falls only once the pipe is full, so nothing is lost or repeated.
// Reset clears the valid bits of all stages; data registers are not reset.
`default_nettype none
module fp_compare_minmax_classify (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [135:0] s_axis_tdata,  // command, is_double, operand_a, operand_b
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [71:0]       m_axis_tdata   // result, invalid
);
    // Stage 1: decode.
    logic               r_v1, r_v2, r_v3;
    logic [2:0]         r_cmd1, r_cmd2;
    logic               r_dbl1, r_dbl2;
    logic [63:0]        r_a1, r_b1, r_a2, r_b2;
    fpcmc_pkg::t_opinfo r_ia1, r_ib1, r_ia2, r_ib2;
    logic               r_lt2, r_eq2, r_mzero2;
    logic [63:0]        r_res3;
    logic               r_inv3;

    logic en1, en2, en3;
    assign en3 = !r_v3 || m_axis_tready;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign s_axis_tready = en1;

    logic [63:0] n_a, n_b;
    logic        n_dbl;
    assign n_dbl = s_axis_tdata[3];
    assign n_a = n_dbl ? s_axis_tdata[67:4] : {32'd0, s_axis_tdata[35:4]};
    assign n_b = n_dbl ? s_axis_tdata[131:68] : {32'd0, s_axis_tdata[99:68]};

    function automatic fpcmc_pkg::t_opinfo decode(input logic [63:0] x, input logic dbl);
        fpcmc_pkg::t_opinfo r;
        if (dbl) begin
            r.sign = x[63];
            r.exp_max = &x[62:52];
            r.exp_zero = ~|x[62:52];
            r.frac_zero = ~|x[51:0];
            r.quiet = x[51];
        end else begin
            r.sign = x[31];
            r.exp_max = &x[30:23];
            r.exp_zero = ~|x[30:23];
            r.frac_zero = ~|x[22:0];
            r.quiet = x[22];
        end
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en1) begin
            r_v1 <= s_axis_tvalid;
        end
        if (en1) begin
            r_cmd1 <= s_axis_tdata[2:0];
            r_dbl1 <= n_dbl;
            r_a1 <= n_a;
            r_b1 <= n_b;
            r_ia1 <= decode(n_a, n_dbl);
            r_ib1 <= decode(n_b, n_dbl);
        end
    end

    // Stage 2: magnitude compare.
    logic [62:0] ma, mb;
    logic        sa, sb, n_mzero, n_lt;
    assign ma = r_dbl1 ? r_a1[62:0] : {32'd0, r_a1[30:0]};
    assign mb = r_dbl1 ? r_b1[62:0] : {32'd0, r_b1[30:0]};
    assign sa = r_ia1.sign;
    assign sb = r_ib1.sign;
    assign n_mzero = (ma == 63'd0) && (mb == 63'd0);
    always_comb begin
        if (n_mzero) n_lt = 1'b0;
        else if (sa != sb) n_lt = sa;
        else n_lt = sa ? (ma > mb) : (ma < mb);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en2) begin
            r_v2 <= r_v1;
        end
        if (en2) begin
            r_cmd2 <= r_cmd1;
            r_dbl2 <= r_dbl1;
            r_a2 <= r_a1;
            r_b2 <= r_b1;
            r_ia2 <= r_ia1;
            r_ib2 <= r_ib1;
            r_lt2 <= n_lt;
            r_eq2 <= (r_a1 == r_b1) || n_mzero;
            r_mzero2 <= n_mzero;
        end
    end

    // Stage 3: result selection.
    logic        an, bn, snan, pick_a;
    logic [63:0] n_res;
    logic        n_inv;
    logic [9:0]  cls;
    assign an = r_ia2.exp_max && !r_ia2.frac_zero;
    assign bn = r_ib2.exp_max && !r_ib2.frac_zero;
    assign snan = (an && !r_ia2.quiet) || (bn && !r_ib2.quiet);

    always_comb begin
        cls = 10'd0;
        if (an) cls[r_ia2.quiet ? 9 : 8] = 1'b1;
        else if (r_ia2.exp_max) cls[r_ia2.sign ? 0 : 7] = 1'b1;
        else if (!r_ia2.exp_zero) cls[r_ia2.sign ? 1 : 6] = 1'b1;
        else if (!r_ia2.frac_zero) cls[r_ia2.sign ? 2 : 5] = 1'b1;
        else cls[r_ia2.sign ? 3 : 4] = 1'b1;
    end

    always_comb begin
        n_res = 64'd0;
        n_inv = 1'b0;
        pick_a = 1'b0;
        case (r_cmd2)
            fpcmc_pkg::CMD_EQ: begin
                n_inv = snan;
                n_res = {63'd0, !(an || bn) && r_eq2};
            end
            fpcmc_pkg::CMD_LE: begin
                n_inv = an || bn;
                n_res = {63'd0, !(an || bn) && (r_eq2 || r_lt2)};
            end
            fpcmc_pkg::CMD_LT: begin
                n_inv = an || bn;
                n_res = {63'd0, !(an || bn) && r_lt2};
            end
            fpcmc_pkg::CMD_MIN, fpcmc_pkg::CMD_MAX: begin
                n_inv = snan;
                if (r_mzero2) begin
                    pick_a = (r_cmd2 == fpcmc_pkg::CMD_MIN) ? r_ia2.sign : !r_ia2.sign;
                end else begin
                    pick_a = (r_cmd2 == fpcmc_pkg::CMD_MIN) ? r_lt2 : !r_lt2;
                end
                if (an && bn) begin
                    n_res = r_dbl2 ? fpcmc_pkg::DP_CANON_NAN : fpcmc_pkg::SP_CANON_NAN;
                end else if (an) begin
                    n_res = r_b2;
                end else if (bn) begin
                    n_res = r_a2;
                end else begin
                    n_res = pick_a ? r_a2 : r_b2;
                end
            end
            fpcmc_pkg::CMD_CLASS: begin
                n_res = {54'd0, cls};
            end
            default: begin
                n_res = 64'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en3) begin
            r_v3 <= r_v2;
        end
        if (en3) begin
            r_res3 <= n_res;
            r_inv3 <= n_inv;
        end
    end

    assign m_axis_tvalid = r_v3;
    assign m_axis_tdata = {7'd0, r_inv3, r_res3};

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && !m_axis_tready |=> r_v3 && $stable(r_res3))
        else $error("output beat changed under stall");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_v1 && r_v2 && r_v3)
        else $error("ready low while pipe not full");
    a_cmpbit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && m_axis_tready && $past(en3) && $past(r_v2)
        && ($past(r_cmd2) == fpcmc_pkg::CMD_LT) |-> r_res3[63:1] == 63'd0)
        else $error("compare result wider than one bit");
endmodule
`default_nettype wire

// ----- bench/tb.sv -----
// Testbench for the floating-point compare, min/max and classify block with a self-checking predictor.
`timescale 1ns / 100ps
module tb;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct {
        logic [2:0]  cmd;
        logic        dbl;
        logic [63:0] a;
        logic [63:0] b;
    } t_item;

    typedef struct {
        logic [63:0] result;
        logic        invalid;
    } t_outcome;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata;   // command, is_double, operand_a, operand_b
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [71:0]  m_axis_tdata;   // result, invalid, padding

    t_item    pending_items[$];
    t_outcome expected_outcomes[$];
    int       error_count;
    int       send_idle_pct;
    int       recv_idle_pct;
    int       quiet_cycles;
    bit       stimulus_done;

    fp_compare_minmax_classify i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_outcome predict_fp_op(t_item it);
        t_outcome r;
        logic [63:0] sgn, mag, frac, expm, qbit, a, b;
        logic an, bn, snan, lt, eq, zz;
        int fb;
        fb = it.dbl ? 52 : 23;
        sgn = it.dbl ? 64'h8000_0000_0000_0000 : 64'h8000_0000;
        mag = sgn - 1;
        frac = (64'd1 << fb) - 1;
        expm = mag & ~frac;
        qbit = 64'd1 << (fb - 1);
        a = it.dbl ? it.a : {32'd0, it.a[31:0]};
        b = it.dbl ? it.b : {32'd0, it.b[31:0]};
        an = ((a & expm) == expm) && ((a & frac) != 0);
        bn = ((b & expm) == expm) && ((b & frac) != 0);
        snan = (an && (a & qbit) == 0) || (bn && (b & qbit) == 0);
        zz = ((a & mag) == 0) && ((b & mag) == 0);
        eq = (a == b) || zz;
        if (zz) lt = 1'b0;
        else if ((a & sgn) != (b & sgn)) lt = (a & sgn) != 0;
        else if ((a & sgn) != 0) lt = (a & mag) > (b & mag);
        else lt = (a & mag) < (b & mag);
        r.result = '0;
        r.invalid = 1'b0;
        case (it.cmd)
            fpcmc_pkg::CMD_EQ: begin
                if (an || bn) r.invalid = snan;
                else r.result = {63'd0, eq};
            end
            fpcmc_pkg::CMD_LE, fpcmc_pkg::CMD_LT: begin
                if (an || bn) r.invalid = 1'b1;
                else r.result = {63'd0, (it.cmd == fpcmc_pkg::CMD_LE) ? (eq || lt) : lt};
            end
            fpcmc_pkg::CMD_MIN, fpcmc_pkg::CMD_MAX: begin
                r.invalid = snan;
                if (an && bn)
                    r.result = it.dbl ? fpcmc_pkg::DP_CANON_NAN : fpcmc_pkg::SP_CANON_NAN;
                else if (an) r.result = b;
                else if (bn) r.result = a;
                else begin
                    if (zz) lt = (a & sgn) != 0;
                    r.result = ((it.cmd == fpcmc_pkg::CMD_MIN) == lt) ? a : b;
                end
            end
            fpcmc_pkg::CMD_CLASS: begin
                if ((a & expm) == expm && (a & frac) != 0)
                    r.result = ((a & qbit) != 0) ? 64'd512 : 64'd256;
                else if ((a & expm) == expm)
                    r.result = ((a & sgn) != 0) ? 64'd1 : 64'd128;
                else if ((a & expm) != 0)
                    r.result = ((a & sgn) != 0) ? 64'd2 : 64'd64;
                else if ((a & frac) != 0)
                    r.result = ((a & sgn) != 0) ? 64'd4 : 64'd32;
                else
                    r.result = ((a & sgn) != 0) ? 64'd8 : 64'd16;
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [63:0] pick_operand(logic dbl);
        logic [63:0] v;
        int kind;
        v = {$urandom, $urandom};
        kind = $urandom_range(0, 9);
        if (dbl) begin
            case (kind)
                0: v[62:52] = 11'h7FF;
                1: v[62:0] = {11'h7FF, 52'd0};
                2: v[62:52] = 11'h000;
                3: v[62:0] = '0;
                4: v[62:0] = {11'h7FF, 1'b1, 51'd0};
                5: v[62:0] = {11'h7FF, 1'b0, 50'd0, 1'b1};
                6: v[62:55] = 8'h40;
                default: ;
            endcase
        end else begin
            case (kind)
                0: v[30:23] = 8'hFF;
                1: v[30:0] = {8'hFF, 23'd0};
                2: v[30:23] = 8'h00;
                3: v[30:0] = '0;
                4: v[30:0] = {8'hFF, 1'b1, 22'd0};
                5: v[30:0] = {8'hFF, 1'b0, 21'd0, 1'b1};
                6: v[30:26] = 5'h10;
                default: ;
            endcase
        end
        return v;
    endfunction

    task automatic queue_item(logic [2:0] cmd, logic dbl, logic [63:0] a, logic [63:0] b);
        t_item it;
        it.cmd = cmd;
        it.dbl = dbl;
        it.a = a;
        it.b = b;
        pending_items.push_back(it);
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) expected_outcomes.push_back(predict_fp_op(pending_items.pop_front()));
            if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {4'd0, pending_items[0].b, pending_items[0].a,
                                 pending_items[0].dbl, pending_items[0].cmd};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor, receiver stalls and watchdog.
    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            m_axis_tready <= $urandom_range(0, 99) >= recv_idle_pct;
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_outcomes.size() == 0) begin
                    report_mismatch("unexpected beat", m_axis_tdata[63:0], '0);
                end else begin
                    want = expected_outcomes.pop_front();
                    if (m_axis_tdata[63:0] !== want.result)
                        report_mismatch("result", m_axis_tdata[63:0], want.result);
                    if (m_axis_tdata[64] !== want.invalid)
                        report_mismatch("invalid", {63'd0, m_axis_tdata[64]},
                                        {63'd0, want.invalid});
                end
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        logic [2:0] c;
        logic d;
        error_count = 0;
        stimulus_done = 1'b0;
        send_idle_pct = 22;
        recv_idle_pct = 82;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed cases: zeros of both signs, infinities, NaNs, subnormals, unused codes.
        queue_item(fpcmc_pkg::CMD_EQ, 1'b0, 64'h8000_0000, 64'h0);
        queue_item(fpcmc_pkg::CMD_LE, 1'b0, 64'h8000_0000, 64'h0);
        queue_item(fpcmc_pkg::CMD_LT, 1'b0, 64'h8000_0000, 64'h0);
        queue_item(fpcmc_pkg::CMD_MIN, 1'b0, 64'h0, 64'h8000_0000);
        queue_item(fpcmc_pkg::CMD_MAX, 1'b1, 64'h8000_0000_0000_0000, 64'h0);
        queue_item(fpcmc_pkg::CMD_EQ, 1'b0, 64'h7FC0_0000, 64'h1);
        queue_item(fpcmc_pkg::CMD_EQ, 1'b0, 64'h7F80_0001, 64'h1);
        queue_item(fpcmc_pkg::CMD_LT, 1'b1, 64'h7FF8_0000_0000_0000, 64'h1);
        queue_item(fpcmc_pkg::CMD_MIN, 1'b0, 64'h7FC0_0000, 64'h7F80_0001);
        queue_item(fpcmc_pkg::CMD_MAX, 1'b1, 64'h7FF0_0000_0000_0001, 64'h3FF0_0000_0000_0000);
        queue_item(fpcmc_pkg::CMD_MIN, 1'b1, 64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000);
        queue_item(fpcmc_pkg::CMD_CLASS, 1'b0, 64'hFF80_0000, 64'h0);
        queue_item(fpcmc_pkg::CMD_CLASS, 1'b0, 64'h0000_0001, 64'h0);
        queue_item(fpcmc_pkg::CMD_CLASS, 1'b1, 64'h800F_FFFF_FFFF_FFFF, 64'h0);
        queue_item(fpcmc_pkg::CMD_CLASS, 1'b1, 64'h7FF4_0000_0000_0000, 64'h0);
        queue_item(fpcmc_pkg::CMD_CLASS, 1'b1, 64'h7FF8_0000_0000_0000, 64'h0);
        queue_item(fpcmc_pkg::CMD_CLASS, 1'b0, 64'hFFFF_FFFF_7F7F_FFFF, 64'h0);
        queue_item(3'd6, 1'b1, '1, '1);
        queue_item(3'd7, 1'b0, '1, '0);
        queue_item(fpcmc_pkg::CMD_LE, 1'b1, '1, '1);

        for (int phase = 0; phase < 3; phase++) begin
            for (int n = 0; n < 410; n++) begin
                c = ($urandom_range(0, 49) == 0) ? 3'($urandom_range(6, 7))
                                                 : 3'($urandom_range(0, 5));
                d = 1'($urandom_range(0, 1));
                if ($urandom_range(0, 3) == 0)
                    queue_item(c, d, pick_operand(d), pick_operand(d) ^ 64'($urandom_range(0, 1)));
                else
                    queue_item(c, d, pick_operand(d), pick_operand(d));
            end
            wait (pending_items.size() == 0 && !s_axis_tvalid);
            if (phase == 0) begin
                send_idle_pct = 82;
                recv_idle_pct = 22;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        end
        wait (expected_outcomes.size() == 0);
        repeat (20) @(posedge i_clk);
        if (error_count == 0 && expected_outcomes.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ----- filelist.f -----
src/fpcmc_pkg.sv
src/fp_compare_minmax_classify.sv
bench/tb.sv
